/* rtl/core/nearest_free_slot_allocator_unit_macros.svh */
// assertion macros for the nearest free slot allocator
// expects signals named clk and rst in the module that uses them
`ifndef NEAREST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define NEAREST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NFSA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("nfsa assertion failed");
`define NFSA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("nfsa assertion failed");
`else
`define NFSA_ASSERT_NOW(label, pre, post)
`define NFSA_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* rtl/core/nfsa_pkg.sv */
// shared types and constants for the nearest free slot allocator
// no dependencies
`timescale 1ns / 1ps

package nfsa_pkg;

  localparam int VALUE_W   = 16;
  localparam int SIZE_W    = 11;
  localparam int INDEX_W   = 10;
  localparam int SLOTS_DEF = 1024;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [VALUE_W-1:0] random_value;
    logic               new_batch;
  } nfsa_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    logic               table_full;
  } nfsa_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK
  } nfsa_state_t;

endpackage

/* rtl/core/nearest_free_slot_allocator_unit.sv */
// Nearest free slot allocator. Each transfer on the input side brings a random word; the
// block takes it modulo n, the table size clamped to 1..SLOTS, with a bit-serial remainder
// unit, then walks a one-bit occupancy ram outward from that slot (start, +1, -1, +2, -2,
// with wrap), each probe a read then a check state as the ram read is registered. The
// first free slot is marked and returned; with no free slot among the first n entries the
// full flag comes back after 2 * n probes. A new request is taken only once the last
// result is loaded, so occupied neighbors and output stalls set the rate. A batch flag,
// and reset itself, start a clear pass over all SLOTS entries, one per cycle, taking no
// request. Depends on nfsa_pkg, nfsa_div, nfsa_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "nearest_free_slot_allocator_unit_macros.svh"

module nearest_free_slot_allocator_unit #(
  parameter int SLOTS = nfsa_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  nfsa_pkg::nfsa_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nfsa_pkg::nfsa_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [nfsa_pkg::SIZE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int SW = nfsa_pkg::SIZE_W;

  nfsa_pkg::nfsa_state_t state, state_next;

  logic [SW-1:0]        table_size;
  logic [SW-1:0]        n_eff;
  logic [AW-1:0]        clr_addr;
  logic                 clr_last;
  logic                 pend;
  nfsa_pkg::nfsa_in_t   item;
  logic [SW-1:0]        up, down, k;
  logic                 dir;
  logic [SW-1:0]        probe_pos;
  logic [AW-1:0]        probe_addr;
  logic                 probe_last;
  logic                 probe_adv;
  logic                 out_free;
  logic                 res_load;
  nfsa_pkg::nfsa_out_t  res_next;

  logic                 div_start;
  logic                 div_done;
  logic [SW-1:0]        div_rem;
  logic [nfsa_pkg::VALUE_W-1:0] div_dividend;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [0:0]           ram_wdata;
  logic                 ram_re;
  logic [0:0]           ram_rdata;

  always_comb begin
    if (table_size == '0) begin
      n_eff = SW'(1);
    end else if (32'(table_size) > SLOTS) begin
      n_eff = SW'(SLOTS);
    end else begin
      n_eff = table_size;
    end
  end

  assign clr_last   = clr_addr == AW'(SLOTS - 1);
  assign probe_pos  = dir ? down : up;
  assign probe_addr = AW'(probe_pos);
  assign probe_last = dir && (k == n_eff - SW'(1));
  assign out_free   = !out_valid || out_ready;
  assign div_dividend = (state == nfsa_pkg::S_IDLE) ? in_data.random_value
                                                    : item.random_value;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nfsa_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_next = pend ? nfsa_pkg::S_DIV : nfsa_pkg::S_IDLE;
        end
      end
      nfsa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = in_data.new_batch ? nfsa_pkg::S_CLEAR : nfsa_pkg::S_DIV;
        end
      end
      nfsa_pkg::S_DIV: begin
        if (div_done) begin
          state_next = nfsa_pkg::S_READ;
        end
      end
      nfsa_pkg::S_READ: begin
        state_next = nfsa_pkg::S_CHECK;
      end
      nfsa_pkg::S_CHECK: begin
        if (res_load) begin
          state_next = nfsa_pkg::S_IDLE;
        end else if (probe_adv) begin
          state_next = nfsa_pkg::S_READ;
        end
      end
      default: state_next = nfsa_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    res_load  = 1'b0;
    res_next  = '0;
    probe_adv = 1'b0;
    unique case (state)
      nfsa_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        div_start = clr_last && pend;
      end
      nfsa_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && !in_data.new_batch;
      end
      nfsa_pkg::S_DIV: begin
      end
      nfsa_pkg::S_READ: begin
        ram_re = 1'b1;
      end
      nfsa_pkg::S_CHECK: begin
        if (!ram_rdata[0]) begin
          if (out_free) begin
            ram_we              = 1'b1;
            ram_waddr           = probe_addr;
            ram_wdata           = 1'b1;
            res_load            = 1'b1;
            res_next.slot_index = probe_pos[nfsa_pkg::INDEX_W-1:0];
            res_next.table_full = 1'b0;
          end
        end else if (probe_last) begin
          if (out_free) begin
            res_load            = 1'b1;
            res_next.table_full = 1'b1;
          end
        end else begin
          probe_adv = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nfsa_pkg::S_CLEAR;
      table_size <= nfsa_pkg::SIZE_RESET;
      clr_addr   <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        table_size <= cfg_wdata;
      end
      if (state == nfsa_pkg::S_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
      end
      if (in_valid && in_ready) begin
        pend <= 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (div_done && state == nfsa_pkg::S_DIV) begin
      up   <= div_rem;
      down <= div_rem;
      k    <= '0;
      dir  <= 1'b0;
    end else if (probe_adv) begin
      if (!dir) begin
        dir <= 1'b1;
      end else begin
        dir  <= 1'b0;
        up   <= (up == n_eff - SW'(1)) ? '0 : up + SW'(1);
        down <= (down == '0) ? n_eff - SW'(1) : down - SW'(1);
        k    <= k + SW'(1);
      end
    end
    if (res_load) begin
      out_data <= res_next;
    end
  end

  nfsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (n_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  nfsa_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (probe_addr),
    .rdata (ram_rdata)
  );

  `NFSA_ASSERT_NOW(a_rem_in_range, div_done, div_rem < n_eff)
  `NFSA_ASSERT_NOW(a_slot_in_range, res_load && !res_next.table_full, probe_pos < n_eff)
  `NFSA_ASSERT_NOW(a_mark_after_free, ram_we && ram_wdata[0], state == nfsa_pkg::S_CHECK && !ram_rdata[0])
  `NFSA_ASSERT_NOW(a_full_after_sweep, res_load && res_next.table_full, dir && k == n_eff - SW'(1))
  `NFSA_ASSERT_NEXT(a_result_held, res_load, out_valid && in_ready)

endmodule

/* rtl/core/nfsa_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module nfsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/nfsa_div.sv */
// iterative restoring remainder unit, one quotient bit per cycle
// depends on nfsa_pkg
`timescale 1ns / 1ps

module nfsa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nfsa_pkg::VALUE_W-1:0] dividend,
  input  logic [nfsa_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [nfsa_pkg::SIZE_W-1:0]  remainder
);

  localparam int CW = $clog2(nfsa_pkg::VALUE_W + 1);

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [nfsa_pkg::VALUE_W-1:0] dvd;
  logic [nfsa_pkg::SIZE_W-1:0]  rem;
  logic [nfsa_pkg::SIZE_W-1:0]  dsr;
  logic [nfsa_pkg::SIZE_W:0]    trial;
  logic [nfsa_pkg::SIZE_W:0]    diff;
  logic [nfsa_pkg::SIZE_W-1:0]  rem_next;

  always_comb begin
    trial = {rem, dvd[nfsa_pkg::VALUE_W-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next = diff[nfsa_pkg::SIZE_W-1:0];
    end else begin
      rem_next = trial[nfsa_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(nfsa_pkg::VALUE_W);
        dvd  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= dvd << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

/* sim/nearest_free_slot_allocator_unit_tb.sv */
// testbench for nearest_free_slot_allocator_unit: a directed table, then random phases
// at many table sizes; typed rows are checked against their listed results, the others
// against a predictor of the occupancy map; depends on nfsa_pkg and the allocator rtl
`timescale 1ns / 1ps

module nearest_free_slot_allocator_unit_tb;

  typedef struct {
    logic                        cfg;
    logic [nfsa_pkg::SIZE_W-1:0] size;
    nfsa_pkg::nfsa_in_t          req;
    logic                        chk;
    nfsa_pkg::nfsa_out_t         want;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  nfsa_pkg::nfsa_in_t          in_data;
  logic                        out_valid;
  logic                        out_ready;
  nfsa_pkg::nfsa_out_t         out_data;
  logic                        cfg_we;
  logic [nfsa_pkg::SIZE_W-1:0] cfg_wdata;

  logic [nfsa_pkg::SLOTS_DEF-1:0] occ_map;
  logic [nfsa_pkg::SIZE_W-1:0]    cur_size;
  nfsa_pkg::nfsa_out_t            grant_q[$];
  stim_row_t                      rows[$];
  logic                           cur_chk;
  nfsa_pkg::nfsa_out_t            cur_want;
  nfsa_pkg::nfsa_out_t            pred_res;
  nfsa_pkg::nfsa_out_t            want_res;
  int                             sent_cnt;
  int                             rcvd_cnt;
  int                             err_cnt;
  int                             tx_pct;
  int                             rx_pct;
  logic                           hold_req;
  logic                           hold_done;
  int                             rand_sent;
  int                             phase_len;
  int                             pick;
  int                             i;
  logic [nfsa_pkg::SIZE_W-1:0]    phase_size;
  nfsa_pkg::nfsa_in_t             rnd_req;

  nearest_free_slot_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic nfsa_pkg::nfsa_out_t predict_grant(nfsa_pkg::nfsa_in_t req);
    int n;
    int r;
    int k;
    int up;
    int dn;
    nfsa_pkg::nfsa_out_t res;
    n = (cur_size == 0) ? 1 : ((cur_size > nfsa_pkg::SLOTS_DEF) ? nfsa_pkg::SLOTS_DEF
                                                                 : int'(cur_size));
    r = int'(req.random_value) % n;
    if (req.new_batch) begin
      occ_map = '0;
    end
    res.slot_index = '0;
    res.table_full = 1'b1;
    for (k = 0; k < n && res.table_full; k++) begin
      up = (r + k) % n;
      dn = (r + n - k) % n;
      if (!occ_map[up]) begin
        occ_map[up] = 1'b1;
        res.slot_index = up[nfsa_pkg::INDEX_W-1:0];
        res.table_full = 1'b0;
      end else if (!occ_map[dn]) begin
        occ_map[dn] = 1'b1;
        res.slot_index = dn[nfsa_pkg::INDEX_W-1:0];
        res.table_full = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic add_row(logic cfg, int size, int value, logic batch, logic chk, int slot,
                         logic full);
    stim_row_t row;
    row.cfg = cfg;
    row.size = size[nfsa_pkg::SIZE_W-1:0];
    row.req.random_value = value[nfsa_pkg::VALUE_W-1:0];
    row.req.new_batch = batch;
    row.chk = chk;
    row.want.slot_index = slot[nfsa_pkg::INDEX_W-1:0];
    row.want.table_full = full;
    rows.insert(rows.size(), row);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (rcvd_cnt != sent_cnt);
  endtask

  task automatic write_size(logic [nfsa_pkg::SIZE_W-1:0] size);
    wait_drain();
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    cur_size = size;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_req(nfsa_pkg::nfsa_in_t req, logic chk, nfsa_pkg::nfsa_out_t want);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    cur_chk <= chk;
    cur_want <= want;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  // receiver side, with one long hold-off to back the block up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (6000) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_pct);
      end
    end
  end

  // transfer monitor and scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred_res = predict_grant(in_data);
        grant_q.insert(grant_q.size(), cur_chk ? cur_want : pred_res);
      end
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual slot %0d full %0b",
                   $time, out_data.slot_index, out_data.table_full);
          err_cnt++;
        end else begin
          want_res = grant_q.pop_front();
          rcvd_cnt++;
          if (out_data.slot_index !== want_res.slot_index) begin
            $display("%0t slot_index mismatch: expected %0d actual %0d",
                     $time, want_res.slot_index, out_data.slot_index);
            err_cnt++;
          end
          if (out_data.table_full !== want_res.table_full) begin
            $display("%0t table_full mismatch: expected %0b actual %0b",
                     $time, want_res.table_full, out_data.table_full);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000_000;
    $display("nearest_free_slot_allocator_unit_tb: errors");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cur_chk = 1'b0;
    cur_want = '0;
    occ_map = '0;
    cur_size = nfsa_pkg::SIZE_RESET;
    sent_cnt = 0;
    rcvd_cnt = 0;
    err_cnt = 0;
    tx_pct = 27;
    rx_pct = 51;
    hold_req = 1'b0;
    hold_done = 1'b0;
    rand_sent = 0;

    // cfg, size, value, batch, typed, slot, full
    add_row(0, 0,    'h0000, 0, 1, 0,    0);
    add_row(0, 0,    'hFFFF, 0, 1, 1023, 0);
    add_row(0, 0,    'h0000, 0, 0, 0,    0);
    add_row(0, 0,    1023,   0, 0, 0,    0);
    add_row(0, 0,    512,    1, 1, 512,  0);
    add_row(1, 1,    'hFFFF, 0, 1, 0,    0);
    add_row(0, 0,    1234,   0, 1, 0,    1);
    add_row(0, 0,    7,      1, 1, 0,    0);
    add_row(1, 0,    5,      0, 1, 0,    1);
    add_row(0, 0,    5,      1, 1, 0,    0);
    add_row(1, 2047, 'hFFFF, 0, 1, 1023, 0);
    add_row(0, 0,    'h8000, 0, 0, 0,    0);
    add_row(1, 3,    2,      1, 1, 2,    0);
    add_row(0, 0,    2,      0, 0, 0,    0);
    add_row(0, 0,    5,      0, 0, 0,    0);
    add_row(0, 0,    0,      0, 1, 0,    1);
    add_row(1, 1024, 'h03FF, 0, 0, 0,    0);
    add_row(0, 0,    'h0001, 0, 0, 0,    0);
    add_row(1, 2,    1,      0, 0, 0,    0);
    add_row(0, 0,    'hAAAA, 1, 1, 0,    0);
    add_row(0, 0,    'h5555, 0, 0, 0,    0);
    add_row(1, 1024, 'h5555, 0, 0, 0,    0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].cfg) begin
        write_size(rows[i].size);
      end
      send_req(rows[i].req, rows[i].chk, rows[i].want);
    end

    while (rand_sent < 1530) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        phase_size = nfsa_pkg::SIZE_W'($urandom_range(1, 64));
      end else if (pick < 85) begin
        phase_size = nfsa_pkg::SIZE_W'($urandom_range(65, 300));
      end else if (pick < 95) begin
        phase_size = nfsa_pkg::SIZE_W'(1024);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            phase_size = nfsa_pkg::SIZE_W'(0);
          end
          1: begin
            phase_size = nfsa_pkg::SIZE_W'(1);
          end
          default: begin
            phase_size = nfsa_pkg::SIZE_W'(2047);
          end
        endcase
      end
      write_size(phase_size);
      phase_len = $urandom_range(40, 90);
      for (i = 0; i < phase_len && rand_sent < 1530; i++) begin
        if (rand_sent == 510) begin
          tx_pct = 51;
          rx_pct = 27;
        end else if (rand_sent == 1020) begin
          tx_pct = 0;
          rx_pct = 0;
        end
        if (rand_sent == 100) begin
          hold_req = 1'b1;
        end
        rnd_req.random_value = nfsa_pkg::VALUE_W'($urandom_range(0, 65535));
        rnd_req.new_batch = ($urandom_range(0, 9) == 0);
        send_req(rnd_req, 1'b0, '0);
        rand_sent++;
      end
    end

    wait_drain();
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("nearest_free_slot_allocator_unit_tb: clean");
    end else begin
      $display("nearest_free_slot_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/nfsa_pkg.sv
rtl/core/nfsa_ram.sv
rtl/core/nfsa_div.sv
rtl/core/nearest_free_slot_allocator_unit.sv
sim/nearest_free_slot_allocator_unit_tb.sv
